// ===== rtl/bapt_pkg.sv =====
`default_nettype none

package bapt_pkg;

    // entry payload, operand, index, epoch tag and stored word widths
    localparam int DATA_W    = 64;
    localparam int OPERAND_W = 32;
    localparam int INDEX_W   = 10;
    localparam int EPOCH_W   = 8;
    localparam int WORD_W    = EPOCH_W + DATA_W;

    localparam int DEFAULT_ENTRIES = 1024;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ASSIGN = 2'd1,
        FUNC_ADD    = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    // stored word: epoch tag on top, entry value below
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [DATA_W-1:0]  data;
    } t_word;

endpackage

`default_nettype wire

// ===== rtl/bapt_in_if.sv =====
`default_nettype none

interface bapt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [9:0]  entry_index;
    logic [31:0] operand_value;

    modport source (output valid, output func, output entry_index, output operand_value,
                    input ready);
    modport sink (input valid, input func, input entry_index, input operand_value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/bapt_out_if.sv =====
`default_nettype none

interface bapt_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] entry_result;

    modport source (output valid, output entry_result, input ready);
    modport sink (input valid, input entry_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/bapt_ram.sv =====
`default_nettype none

module bapt_ram #(
    parameter int ENTRIES = bapt_pkg::DEFAULT_ENTRIES,
    parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [ADDR_W-1:0]     i_wr_addr,
    input  wire bapt_pkg::t_word       i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [ADDR_W-1:0]     i_rd_addr,
    output bapt_pkg::t_word            o_rd_data
);
    import bapt_pkg::*;

    t_word r_mem [ENTRIES];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/bapt_clear.sv =====
`default_nettype none

module bapt_clear #(
    parameter int ENTRIES = bapt_pkg::DEFAULT_ENTRIES,
    parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    output logic [ADDR_W-1:0]      o_addr
);
    logic              r_busy;
    logic              n_busy;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] n_cnt;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (r_busy) begin
            if (r_cnt == ADDR_W'(ENTRIES - 1)) begin
                n_busy = 1'b0;
                n_cnt  = '0;
            end else begin
                n_cnt = r_cnt + ADDR_W'(1);
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end
    end

    // sweep runs right after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_cnt;

endmodule

`default_nettype wire

// ===== rtl/bulk_assign_point_add_table.sv =====
`default_nettype none

// channel   dir  handshake          payload
// i_in      in   valid / ready      func, entry_index, operand_value
// o_out     out  valid / ready      entry_result (reads only)
//
// one op per cycle while i_in.ready is high: a beat issues its memory read,
// the second stage resolves the entry and writes back, so throughput is set by
// the single ram write port; after reset, and after every 255th assign-all, a
// tag sweep over all ENTRIES entries runs with i_in.ready low
// a read stalls in the second stage only while the output register is full
// and o_out.ready is low
// an assign-all that wraps the epoch holds i_in.ready low until the sweep ends

module bulk_assign_point_add_table #(
    parameter int ENTRIES = bapt_pkg::DEFAULT_ENTRIES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bapt_in_if.sink    i_in,
    bapt_out_if.source o_out
);
    import bapt_pkg::*;

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMP_W  = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 2;

    // input decode
    logic                      in_acc;
    logic                      in_hit;
    logic [CMP_W-1:0]          idx_ext;
    logic [ADDR_W+INDEX_W-1:0] addr_ext;
    logic [ADDR_W-1:0]         in_addr;

    // second stage: entry resolve and write back
    logic                 r_s2_valid, n_s2_valid;
    t_func                r_s2_func,  n_s2_func;
    logic [ADDR_W-1:0]    r_s2_addr,  n_s2_addr;
    logic                 r_s2_hit,   n_s2_hit;
    logic [OPERAND_W-1:0] r_s2_val,   n_s2_val;

    // bypass for a write landing in the same cycle as the read
    logic  r_fwd, n_fwd;
    t_word r_fwd_word, n_fwd_word;

    // table-wide state: base value and current epoch
    logic [DATA_W-1:0]  r_base,  n_base;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data,  n_out_data;

    t_word             rd_word;
    t_word             cur_word;
    logic [DATA_W-1:0] cur_value;
    logic [DATA_W-1:0] sum;
    logic              out_free;
    logic              s2_go;
    logic              s2_wr;
    t_word             s2_wr_word;
    logic              wrap_pend;
    logic              clr_start;
    logic              clr_busy;
    logic [ADDR_W-1:0] clr_addr;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    t_word             ram_wr_data;

    assign idx_ext  = CMP_W'(i_in.entry_index);
    assign in_hit   = idx_ext < CMP_W'(ENTRIES);
    assign addr_ext = {{ADDR_W{1'b0}}, i_in.entry_index};
    assign in_addr  = addr_ext[ADDR_W-1:0];

    // entry is live only if its tag matches the current epoch
    assign cur_word  = r_fwd ? r_fwd_word : rd_word;
    assign cur_value = (cur_word.tag == r_epoch) ? cur_word.data : r_base;
    assign sum       = cur_value + DATA_W'(r_s2_val);

    assign out_free = !r_out_valid || o_out.ready;
    assign s2_go    = (r_s2_func != FUNC_READ) || out_free;
    assign s2_wr    = r_s2_valid && r_s2_hit
                   && ((r_s2_func == FUNC_LOAD) || (r_s2_func == FUNC_ADD));

    assign s2_wr_word.tag  = r_epoch;
    assign s2_wr_word.data = (r_s2_func == FUNC_LOAD) ? DATA_W'(r_s2_val) : sum;

    // a wrapping epoch needs the sweep before any new beat reads a tag
    assign wrap_pend = r_s2_valid && (r_s2_func == FUNC_ASSIGN) && (r_epoch == '1);
    assign clr_start = wrap_pend;

    assign i_in.ready = !clr_busy && !wrap_pend && (!r_s2_valid || s2_go);
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        n_s2_valid  = r_s2_valid;
        n_s2_func   = r_s2_func;
        n_s2_addr   = r_s2_addr;
        n_s2_hit    = r_s2_hit;
        n_s2_val    = r_s2_val;
        n_fwd       = r_fwd;
        n_fwd_word  = r_fwd_word;
        n_base      = r_base;
        n_epoch     = r_epoch;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (in_acc) begin
            n_s2_valid = 1'b1;
            n_s2_func  = t_func'(i_in.func);
            n_s2_addr  = in_addr;
            n_s2_hit   = in_hit;
            n_s2_val   = i_in.operand_value;
            n_fwd      = s2_wr && (r_s2_addr == in_addr);
            n_fwd_word = s2_wr_word;
        end else if (s2_go) begin
            n_s2_valid = 1'b0;
        end

        if (r_s2_valid && (r_s2_func == FUNC_ASSIGN)) begin
            n_base  = DATA_W'(r_s2_val);
            n_epoch = (r_epoch == '1) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
        end

        if (r_s2_valid && (r_s2_func == FUNC_READ) && out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = r_s2_hit ? cur_value : '0;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_base      <= '0;
            r_epoch     <= EPOCH_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_s2_valid  <= n_s2_valid;
            r_fwd       <= n_fwd;
            r_base      <= n_base;
            r_epoch     <= n_epoch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_func  <= n_s2_func;
        r_s2_addr  <= n_s2_addr;
        r_s2_hit   <= n_s2_hit;
        r_s2_val   <= n_s2_val;
        r_fwd_word <= n_fwd_word;
        r_out_data <= n_out_data;
    end

    // sweep owns the write port; no beat is in flight while it runs
    always_comb begin
        if (clr_busy) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = s2_wr;
            ram_wr_addr = r_s2_addr;
            ram_wr_data = s2_wr_word;
        end
    end

    bapt_ram #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_word)
    );

    bapt_clear #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (clr_start),
        .o_busy  (clr_busy),
        .o_addr  (clr_addr)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.entry_result = r_out_data;

endmodule

`default_nettype wire
